FILE: rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the easing curve evaluator.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition in this cycle implies the consequence in the same cycle.
`define ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Condition in this cycle implies the consequence in the next cycle.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/ecev_pkg.sv
// Shared constants, types and codes of the easing curve evaluator.
`default_nettype none

package ecev_pkg;

  // Fixed-point format and internal widths.
  localparam int FRAC_BITS    = 16;
  localparam int ONE          = 1 << FRAC_BITS;
  localparam int Y_LIMIT      = 4 * ONE;
  localparam int VAL_W        = FRAC_BITS + 1;
  localparam int OP_W         = 21;
  localparam int ACC_W        = 24;
  localparam int IN_W         = 18;
  localparam int OUT_W        = 20;
  localparam int CFG_W        = 20;
  localparam int ROUNDS_DEF   = 24;

  // Curve selection codes.
  typedef enum logic [2:0] {
    CK_LINEAR         = 3'd0,
    CK_EASE_IN        = 3'd1,
    CK_EASE_OUT       = 3'd2,
    CK_EASE_IN_OUT    = 3'd3,
    CK_EASE_OUT_CUBIC = 3'd4,
    CK_BEZIER         = 3'd5,
    CK_STEPS          = 3'd6
  } curve_kind_e;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_KIND     = 3'd0,
    REG_X_FIRST  = 3'd1,
    REG_X_SECOND = 3'd2,
    REG_Y_FIRST  = 3'd3,
    REG_Y_SECOND = 3'd4,
    REG_STEPS    = 3'd5,
    REG_AT_START = 3'd6
  } reg_idx_e;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIMPLE,
    ST_CUBE,
    ST_BEZ,
    ST_STEP_MUL,
    ST_STEP_DIV
  } state_e;

endpackage

`default_nettype wire

FILE: rtl/ecev_fmul.sv
// Shared fixed-point multiplier with magnitude truncation toward zero.
`default_nettype none

module ecev_fmul (
  input  logic signed [ecev_pkg::OP_W-1:0]  a_i,
  input  logic signed [ecev_pkg::OP_W-1:0]  b_i,
  output logic signed [ecev_pkg::ACC_W-1:0] prod_o
);

  logic [ecev_pkg::OP_W-1:0]   mag_a;
  logic [ecev_pkg::OP_W-1:0]   mag_b;
  logic [2*ecev_pkg::OP_W-1:0] mag_p;
  logic [ecev_pkg::ACC_W-1:0]  mag_r;
  logic                        neg;

  // Multiply magnitudes, drop the fraction, then restore the sign.
  always_comb begin
    mag_a  = a_i[ecev_pkg::OP_W-1] ? ecev_pkg::OP_W'(-a_i) : ecev_pkg::OP_W'(a_i);
    mag_b  = b_i[ecev_pkg::OP_W-1] ? ecev_pkg::OP_W'(-b_i) : ecev_pkg::OP_W'(b_i);
    neg    = a_i[ecev_pkg::OP_W-1] ^ b_i[ecev_pkg::OP_W-1];
    mag_p  = (2*ecev_pkg::OP_W)'(mag_a) * (2*ecev_pkg::OP_W)'(mag_b);
    mag_r  = mag_p[ecev_pkg::FRAC_BITS +: ecev_pkg::ACC_W];
    prod_o = neg ? -$signed(mag_r) : $signed(mag_r);
  end

endmodule

`default_nettype wire

FILE: rtl/ecev_div.sv
// Restoring divider giving the fraction bits of num / den for num below den.
`default_nettype none

module ecev_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              start_i,
  input  logic [ecev_pkg::VAL_W-1:0]        num_i,
  input  logic [ecev_pkg::VAL_W-1:0]        den_i,
  output logic                              done_o,
  output logic [ecev_pkg::FRAC_BITS-1:0]    quot_o
);

  localparam int CntW = $clog2(ecev_pkg::FRAC_BITS + 1);

  logic [ecev_pkg::VAL_W-1:0]     rem_q, rem_d;
  logic [ecev_pkg::FRAC_BITS-1:0] quot_q, quot_d;
  logic [CntW-1:0]                cnt_q, cnt_d;
  logic                           run_q, run_d;
  logic                           done_q, done_d;
  logic [ecev_pkg::VAL_W:0]       rem2;
  logic                           fits;

  // One quotient bit per cycle.
  always_comb begin
    rem2   = {rem_q, 1'b0};
    fits   = rem2 >= {1'b0, den_i};
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    run_d  = run_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d = num_i;
      cnt_d = '0;
      run_d = 1'b1;
    end else if (run_q) begin
      rem_d  = fits ? ecev_pkg::VAL_W'(rem2 - {1'b0, den_i}) : ecev_pkg::VAL_W'(rem2);
      quot_d = {quot_q[ecev_pkg::FRAC_BITS-2:0], fits};
      cnt_d  = cnt_q + 1'b1;
      if (cnt_q == CntW'(ecev_pkg::FRAC_BITS - 1)) begin
        run_d  = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      run_q  <= run_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

`default_nettype wire

FILE: rtl/easing_curve_evaluator_core.sv
// Top level of the easing curve evaluator: registers, sequencer and datapath.
//
// Usage. Write the curve registers through cfg_we_i / cfg_index_i / cfg_wdata_i
// while the block is idle; index seven is ignored. A progress word is taken
// on a rising edge where start is high and busy is low. The eased word
// appears on eased_value_o for exactly one cycle with done_o high; the
// receiver cannot stall it, so it must be captured in that cycle.
// Path from the accepting edge to the done_o edge: progress out of the open
// interval, linear and empty-steps curves finish straight from idle; ease
// in, ease out and ease in-out pass through the simple state; ease-out cubic
// takes two products; steps takes one product and, unless the count is
// reached, runs the divider, as does the first step at or below zero progress;
// Bezier runs BISECT_ROUNDS bisection rounds and a final evaluation, with
// the one shared multiplier doing seven products per curve evaluation.
// One word is worked on at a time; a new word may be started in the cycle
// done_o is high. Reset restores the register defaults (linear curve,
// Bezier control points at the identity) and aborts any word in progress.
`default_nettype none

`include "assert_macros.svh"

module easing_curve_evaluator_core #(
  parameter int BISECT_ROUNDS = ecev_pkg::ROUNDS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [2:0]                          cfg_index_i,
  input  logic [ecev_pkg::CFG_W-1:0]          cfg_wdata_i,
  input  logic                                start,
  input  logic signed [ecev_pkg::IN_W-1:0]    progress_i,
  output logic                                busy,
  output logic                                done_o,
  output logic signed [ecev_pkg::OUT_W-1:0]   eased_value_o
);

  localparam int RndW = $clog2(BISECT_ROUNDS);
  localparam int VW   = ecev_pkg::VAL_W;
  localparam int AW   = ecev_pkg::ACC_W;
  localparam int OW   = ecev_pkg::OP_W;

  // Configuration registers.
  logic [2:0]                    kind_q;
  logic [VW-1:0]                 x1_q, x2_q, steps_q;
  logic [ecev_pkg::CFG_W-1:0]    y1_q, y2_q;
  logic                          at_start_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q     <= ecev_pkg::CK_LINEAR;
      x1_q       <= '0;
      x2_q       <= VW'(ecev_pkg::ONE);
      y1_q       <= '0;
      y2_q       <= ecev_pkg::CFG_W'(ecev_pkg::ONE);
      steps_q    <= '0;
      at_start_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        ecev_pkg::REG_KIND:     kind_q     <= cfg_wdata_i[2:0];
        ecev_pkg::REG_X_FIRST:  x1_q       <= cfg_wdata_i[VW-1:0];
        ecev_pkg::REG_X_SECOND: x2_q       <= cfg_wdata_i[VW-1:0];
        ecev_pkg::REG_Y_FIRST:  y1_q       <= cfg_wdata_i;
        ecev_pkg::REG_Y_SECOND: y2_q       <= cfg_wdata_i;
        ecev_pkg::REG_STEPS:    steps_q    <= cfg_wdata_i[VW-1:0];
        ecev_pkg::REG_AT_START: at_start_q <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // Saturated Bezier control points.
  logic signed [OW-1:0] cx1, cx2, cy1, cy2;

  always_comb begin
    cx1 = (x1_q > VW'(ecev_pkg::ONE)) ? OW'(ecev_pkg::ONE) : $signed(OW'(x1_q));
    cx2 = (x2_q > VW'(ecev_pkg::ONE)) ? OW'(ecev_pkg::ONE) : $signed(OW'(x2_q));
    if ($signed(y1_q) > $signed(ecev_pkg::CFG_W'(ecev_pkg::Y_LIMIT)))
      cy1 = OW'(ecev_pkg::Y_LIMIT);
    else if ($signed(y1_q) < -$signed(ecev_pkg::CFG_W'(ecev_pkg::Y_LIMIT)))
      cy1 = -OW'(ecev_pkg::Y_LIMIT);
    else
      cy1 = OW'($signed(y1_q));
    if ($signed(y2_q) > $signed(ecev_pkg::CFG_W'(ecev_pkg::Y_LIMIT)))
      cy2 = OW'(ecev_pkg::Y_LIMIT);
    else if ($signed(y2_q) < -$signed(ecev_pkg::CFG_W'(ecev_pkg::Y_LIMIT)))
      cy2 = -OW'(ecev_pkg::Y_LIMIT);
    else
      cy2 = OW'($signed(y2_q));
  end

  // Sequencer and datapath registers.
  ecev_pkg::state_e          state_q, state_d;
  logic [2:0]                step_q;
  logic [RndW-1:0]           round_q;
  logic                      final_q;
  logic [VW-1:0]             u_q, lo_q, hi_q, t_q;
  logic signed [AW-1:0]      ss_q, uu_q, tmp_q, acc_q;
  logic signed [ecev_pkg::OUT_W-1:0] result_q;
  logic                      done_q;

  logic                      accept;
  logic signed [OW-1:0]      mul_a, mul_b;
  logic signed [AW-1:0]      prod;
  logic [VW-1:0]             s_val;
  logic [OW-1:0]             two_minus_u;
  logic                      t_le0, t_ge1, start_step0;
  logic [VW:0]               n_val;
  logic                      n_lt;
  logic                      div_start;
  logic [VW-1:0]             div_num;
  logic                      div_done;
  logic [ecev_pkg::FRAC_BITS-1:0] div_quot;
  logic                      acc_lt_t;
  logic [VW-1:0]             mid_a, mid_b;
  logic [VW:0]               mid_sum;

  assign accept      = start && (state_q == ecev_pkg::ST_IDLE);
  assign busy        = (state_q != ecev_pkg::ST_IDLE);
  assign t_le0       = (progress_i <= 0);
  assign t_ge1       = (progress_i >= $signed(ecev_pkg::IN_W'(ecev_pkg::ONE)));
  assign start_step0 = (kind_q == ecev_pkg::CK_STEPS) && at_start_q && (steps_q != '0);
  assign s_val       = VW'(ecev_pkg::ONE) - u_q;
  assign two_minus_u = OW'(2 * ecev_pkg::ONE) - OW'(u_q);
  assign n_val       = (VW+1)'(prod[VW-1:0]) + (VW+1)'(at_start_q);
  assign n_lt        = n_val < {1'b0, steps_q};
  assign acc_lt_t    = acc_q < $signed(AW'(t_q));

  // Next bisection midpoint after this round's compare.
  assign mid_a   = acc_lt_t ? u_q : lo_q;
  assign mid_b   = acc_lt_t ? hi_q : u_q;
  assign mid_sum = (VW+1)'(mid_a) + (VW+1)'(mid_b);

  // Divider launch: first-step case at or below zero progress, or a steps quotient.
  always_comb begin
    div_start = 1'b0;
    div_num   = n_val[VW-1:0];
    if (accept && t_le0 && start_step0 && (steps_q != VW'(1))) begin
      div_start = 1'b1;
      div_num   = VW'(1);
    end else if (state_q == ecev_pkg::ST_STEP_MUL && n_lt) begin
      div_start = 1'b1;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ecev_pkg::ST_IDLE: begin
        if (start) begin
          if (t_le0) begin
            if (div_start) state_d = ecev_pkg::ST_STEP_DIV;
          end else if (!t_ge1) begin
            case (kind_q)
              ecev_pkg::CK_EASE_IN,
              ecev_pkg::CK_EASE_OUT,
              ecev_pkg::CK_EASE_IN_OUT:    state_d = ecev_pkg::ST_SIMPLE;
              ecev_pkg::CK_EASE_OUT_CUBIC: state_d = ecev_pkg::ST_CUBE;
              ecev_pkg::CK_BEZIER:         state_d = ecev_pkg::ST_BEZ;
              ecev_pkg::CK_STEPS: begin
                if (steps_q != '0) state_d = ecev_pkg::ST_STEP_MUL;
              end
              default: ;
            endcase
          end
        end
      end
      ecev_pkg::ST_SIMPLE: state_d = ecev_pkg::ST_IDLE;
      ecev_pkg::ST_CUBE: begin
        if (step_q != '0) state_d = ecev_pkg::ST_IDLE;
      end
      ecev_pkg::ST_BEZ: begin
        if (step_q == 3'd7 && final_q) state_d = ecev_pkg::ST_IDLE;
      end
      ecev_pkg::ST_STEP_MUL: state_d = n_lt ? ecev_pkg::ST_STEP_DIV : ecev_pkg::ST_IDLE;
      ecev_pkg::ST_STEP_DIV: begin
        if (div_done) state_d = ecev_pkg::ST_IDLE;
      end
      default: state_d = ecev_pkg::ST_IDLE;
    endcase
  end

  // Multiplier operand selection.
  always_comb begin
    mul_a = $signed(OW'(u_q));
    mul_b = $signed(OW'(u_q));
    case (state_q)
      ecev_pkg::ST_SIMPLE: begin
        if (kind_q == ecev_pkg::CK_EASE_OUT) begin
          mul_b = $signed(two_minus_u);
        end else if (kind_q == ecev_pkg::CK_EASE_IN_OUT &&
                     u_q >= VW'(ecev_pkg::ONE / 2)) begin
          mul_a = $signed(OW'(s_val));
          mul_b = $signed(OW'(s_val));
        end
      end
      ecev_pkg::ST_CUBE: begin
        mul_a = (step_q == '0) ? $signed(OW'(s_val)) : OW'(ss_q);
        mul_b = $signed(OW'(s_val));
      end
      ecev_pkg::ST_BEZ: begin
        case (step_q)
          3'd0: begin
            mul_a = $signed(OW'(s_val));
            mul_b = $signed(OW'(s_val));
          end
          3'd2: mul_a = OW'(ss_q);
          3'd3: begin
            mul_a = OW'(tmp_q);
            mul_b = final_q ? cy1 : cx1;
          end
          3'd4: begin
            mul_a = $signed(OW'(s_val));
            mul_b = OW'(uu_q);
          end
          3'd5: begin
            mul_a = OW'(tmp_q);
            mul_b = final_q ? cy2 : cx2;
          end
          3'd6: mul_a = OW'(uu_q);
          default: ;
        endcase
      end
      ecev_pkg::ST_STEP_MUL: mul_b = $signed(OW'(steps_q));
      default: ;
    endcase
  end

  ecev_fmul u_fmul (
    .a_i    (mul_a),
    .b_i    (mul_b),
    .prod_o (prod)
  );

  ecev_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (steps_q),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ecev_pkg::ST_IDLE;
      step_q  <= '0;
      round_q <= '0;
      final_q <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (accept) begin
        step_q  <= '0;
        round_q <= '0;
        final_q <= 1'b0;
        done_q  <= (state_d == ecev_pkg::ST_IDLE);
      end else begin
        case (state_q)
          ecev_pkg::ST_SIMPLE: done_q <= 1'b1;
          ecev_pkg::ST_CUBE: begin
            step_q <= step_q + 1'b1;
            done_q <= (step_q != '0);
          end
          ecev_pkg::ST_BEZ: begin
            step_q <= step_q + 1'b1;
            done_q <= (step_q == 3'd7) && final_q;
            if (step_q == 3'd7 && !final_q) begin
              if (round_q == RndW'(BISECT_ROUNDS - 1)) begin
                final_q <= 1'b1;
              end else begin
                round_q <= round_q + 1'b1;
              end
            end
          end
          ecev_pkg::ST_STEP_MUL: done_q <= !n_lt;
          ecev_pkg::ST_STEP_DIV: done_q <= div_done;
          default: done_q <= 1'b0;
        endcase
      end
    end
  end

  // Datapath registers and the result word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      t_q  <= progress_i[VW-1:0];
      u_q  <= (kind_q == ecev_pkg::CK_BEZIER) ? VW'(ecev_pkg::ONE / 2) : progress_i[VW-1:0];
      lo_q <= '0;
      hi_q <= VW'(ecev_pkg::ONE);
      if (t_le0) begin
        result_q <= start_step0 ? ecev_pkg::OUT_W'(ecev_pkg::ONE) : '0;
      end else if (t_ge1) begin
        result_q <= ecev_pkg::OUT_W'(ecev_pkg::ONE);
      end else begin
        result_q <= ecev_pkg::OUT_W'(progress_i);
      end
    end else begin
      case (state_q)
        ecev_pkg::ST_SIMPLE: begin
          if (kind_q == ecev_pkg::CK_EASE_IN_OUT) begin
            if (u_q < VW'(ecev_pkg::ONE / 2))
              result_q <= ecev_pkg::OUT_W'(prod <<< 1);
            else
              result_q <= ecev_pkg::OUT_W'(AW'(ecev_pkg::ONE) - (prod <<< 1));
          end else begin
            result_q <= ecev_pkg::OUT_W'(prod);
          end
        end
        ecev_pkg::ST_CUBE: begin
          if (step_q == '0) ss_q <= prod;
          else result_q <= ecev_pkg::OUT_W'(AW'(ecev_pkg::ONE) - prod);
        end
        ecev_pkg::ST_BEZ: begin
          case (step_q)
            3'd0: ss_q  <= prod;
            3'd1: uu_q  <= prod;
            3'd2: tmp_q <= prod;
            3'd3: acc_q <= prod + (prod <<< 1);
            3'd4: tmp_q <= prod;
            3'd5: acc_q <= acc_q + prod + (prod <<< 1);
            3'd6: acc_q <= acc_q + prod;
            default: begin
              // Round end: narrow the interval, or saturate the final y.
              if (final_q) begin
                if (acc_q > $signed(AW'(ecev_pkg::Y_LIMIT)))
                  result_q <= ecev_pkg::OUT_W'(ecev_pkg::Y_LIMIT);
                else if (acc_q < -$signed(AW'(ecev_pkg::Y_LIMIT)))
                  result_q <= -ecev_pkg::OUT_W'(ecev_pkg::Y_LIMIT);
                else
                  result_q <= ecev_pkg::OUT_W'(acc_q);
              end else begin
                if (acc_lt_t) lo_q <= u_q;
                else          hi_q <= u_q;
                u_q <= mid_sum[VW:1];
              end
            end
          endcase
        end
        ecev_pkg::ST_STEP_MUL: result_q <= ecev_pkg::OUT_W'(ecev_pkg::ONE);
        ecev_pkg::ST_STEP_DIV: begin
          if (div_done) result_q <= ecev_pkg::OUT_W'(div_quot);
        end
        default: ;
      endcase
    end
  end

  assign done_o        = done_q;
  assign eased_value_o = result_q;

  // Checks on the sequencer.
  `ASSERT_SAME(a_done_idle, done_q, !busy, "result word shown while still busy")
  `ASSERT_SAME(a_final_round, final_q, round_q == RndW'(BISECT_ROUNDS - 1),
               "final Bezier evaluation before all bisection rounds")
  `ASSERT_SAME(a_interval, state_q == ecev_pkg::ST_BEZ,
               (lo_q <= hi_q) && (hi_q <= VW'(ecev_pkg::ONE)), "bisection interval broken")
  `ASSERT_NEXT(a_bez_end, state_q == ecev_pkg::ST_BEZ && step_q == 3'd7 && final_q,
               done_q, "Bezier result word not delivered")

endmodule

`default_nettype wire
